// ----- src/ocmp_pkg.sv -----
package ocmp_pkg;

  localparam int unsigned HistDepth = 8;

  localparam logic [7:0] ChSlash  = 8'h2F;  // '/'
  localparam logic [7:0] ChZero   = 8'h30;  // '0'
  localparam logic [7:0] ChOne    = 8'h31;
  localparam logic [7:0] ChTwo    = 8'h32;
  localparam logic [7:0] ChFour   = 8'h34;
  localparam logic [7:0] ChD      = 8'h64;
  localparam logic [7:0] ChE      = 8'h65;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ChY      = 8'h79;
  localparam logic [7:0] ChP      = 8'h70;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChS      = 8'h73;
  localparam logic [7:0] ChH      = 8'h68;
  localparam logic [7:0] ChG      = 8'h67;
  localparam logic [7:0] ChL      = 8'h6C;

  localparam logic [3:0] CntFader  = 4'd11;
  localparam logic [3:0] CntXy     = 4'd14;
  localparam logic [3:0] CntPush   = 4'd10;
  localparam logic [3:0] CntToggle = 4'd10;

  localparam logic [5:0] CmdNone      = 6'd0;
  localparam logic [5:0] CmdFaderBase = 6'd0;
  localparam logic [5:0] CmdXyBase    = 6'd10;
  localparam logic [5:0] CmdPushBase  = 6'd20;
  localparam logic [5:0] CmdTogBase   = 6'd30;

  localparam logic EvUpdate  = 1'b0;
  localparam logic EvRestart = 1'b1;

  localparam logic [2:0] KindNone   = 3'd0;
  localparam logic [2:0] KindFader  = 3'd1;
  localparam logic [2:0] KindXy     = 3'd2;
  localparam logic [2:0] KindPush   = 3'd3;
  localparam logic [2:0] KindToggle = 3'd4;

  localparam int unsigned DataW = 88;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_NAME  = 2'd1,
    PH_COUNT = 2'd2
  } phase_t;

  typedef struct packed {
    logic        event_res;
    logic [2:0]  control_kind;
    logic [2:0]  control_number;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic        switch_on;
    logic        range_error_a;
    logic        range_error_b;
    logic [7:0]  page;
  } res_t;

  // True when the single-precision word is below 0.0 or above 1.0; NaN never.
  function automatic logic out_of_unit(input logic [31:0] w);
    logic [30:0] mag;
    mag = w[30:0];
    if (mag > 31'h7F80_0000) begin
      return 1'b0;
    end else if (w[31]) begin
      return mag != 31'd0;
    end else begin
      return mag > 31'h3F80_0000;
    end
  endfunction

endpackage

// ----- src/ocmp_parser.sv -----
module ocmp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  output ocmp_pkg::res_t     res
);
  import ocmp_pkg::*;

  logic [7:0]  hist_r [HistDepth];
  logic [7:0]  hist_nxt [HistDepth];
  phase_t      phase_r, phase_nxt;
  logic [3:0]  btv_r, btv_nxt;
  logic        two_r, two_nxt;
  logic [5:0]  cmd_r, cmd_nxt;
  logic [7:0]  page_r, page_nxt;

  logic        dig_ok;
  logic [5:0]  dig_val;
  logic [31:0] word_a, word_b;

  always_comb begin
    hist_nxt[0] = rx_byte;
    for (int i = 1; i < HistDepth; i++) begin
      hist_nxt[i] = hist_r[i-1];
    end
  end

  assign dig_ok  = (rx_byte >= ChOne) && (rx_byte <= ChFour);
  assign dig_val = {2'b00, rx_byte[3:0]};
  assign word_a  = {hist_nxt[3], hist_nxt[2], hist_nxt[1], hist_nxt[0]};
  assign word_b  = {hist_nxt[7], hist_nxt[6], hist_nxt[5], hist_nxt[4]};

  always_comb begin
    phase_nxt = phase_r;
    btv_nxt   = btv_r;
    two_nxt   = two_r;
    cmd_nxt   = cmd_r;
    page_nxt  = page_r;
    res_valid = 1'b0;
    res       = '0;
    res.page  = page_r;

    if (hist_nxt[0] == ChSlash && hist_nxt[2] == ChSlash) begin
      phase_nxt = PH_NAME;
      if (phase_r == PH_IDLE) begin
        page_nxt = hist_nxt[1] - ChZero;
      end else begin
        res_valid     = 1'b1;
        res.event_res = EvRestart;
      end
    end else begin
      case (phase_r)
        PH_NAME: begin
          if (hist_nxt[3] == ChD && hist_nxt[2] == ChE && hist_nxt[1] == ChR) begin
            phase_nxt = PH_COUNT;
            btv_nxt   = CntFader;
            two_nxt   = 1'b0;
            if (dig_ok) cmd_nxt = CmdFaderBase + dig_val;
          end else if (hist_nxt[2] == ChX && hist_nxt[1] == ChY) begin
            phase_nxt = PH_COUNT;
            btv_nxt   = CntXy;
            two_nxt   = 1'b1;
            cmd_nxt   = (rx_byte == ChTwo) ? CmdXyBase + 6'd2 : CmdXyBase + 6'd1;
          end else if (hist_nxt[4] == ChP && hist_nxt[3] == ChU &&
                       hist_nxt[2] == ChS && hist_nxt[1] == ChH) begin
            phase_nxt = PH_COUNT;
            btv_nxt   = CntPush;
            two_nxt   = 1'b0;
            if (dig_ok) cmd_nxt = CmdPushBase + dig_val;
          end else if (hist_nxt[3] == ChG && hist_nxt[2] == ChL &&
                       hist_nxt[1] == ChE) begin
            phase_nxt = PH_COUNT;
            btv_nxt   = CntToggle;
            two_nxt   = 1'b0;
            if (dig_ok) cmd_nxt = CmdTogBase + dig_val;
          end
        end
        PH_COUNT: begin
          if (btv_r > 4'd1) begin
            btv_nxt = btv_r - 4'd1;
          end else begin
            btv_nxt   = 4'd0;
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
            res.event_res = EvUpdate;
            if (cmd_r >= CmdFaderBase + 6'd1 && cmd_r <= CmdFaderBase + 6'd4) begin
              res.control_kind   = KindFader;
              res.control_number = 3'(cmd_r - CmdFaderBase);
            end else if (cmd_r >= CmdXyBase + 6'd1 && cmd_r <= CmdXyBase + 6'd2) begin
              res.control_kind   = KindXy;
              res.control_number = 3'(cmd_r - CmdXyBase);
            end else if (cmd_r >= CmdPushBase + 6'd1 && cmd_r <= CmdPushBase + 6'd4) begin
              res.control_kind   = KindPush;
              res.control_number = 3'(cmd_r - CmdPushBase);
            end else if (cmd_r >= CmdTogBase + 6'd1 && cmd_r <= CmdTogBase + 6'd4) begin
              res.control_kind   = KindToggle;
              res.control_number = 3'(cmd_r - CmdTogBase);
            end else begin
              res.control_kind   = KindNone;
              res.control_number = 3'd0;
            end
            res.value_a       = word_a;
            res.value_b       = two_r ? word_b : 32'd0;
            res.switch_on     = word_a[30:0] != 31'd0;
            res.range_error_a = out_of_unit(word_a);
            res.range_error_b = two_r ? out_of_unit(word_b) : 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (!take) begin
      phase_nxt = phase_r;
      btv_nxt   = btv_r;
      two_nxt   = two_r;
      cmd_nxt   = cmd_r;
      page_nxt  = page_r;
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HistDepth; i++) begin
        hist_r[i] <= 8'd0;
      end
      phase_r <= PH_IDLE;
      btv_r   <= 4'd0;
      two_r   <= 1'b0;
      cmd_r   <= CmdNone;
      page_r  <= 8'd0;
    end else begin
      if (take) begin
        for (int i = 0; i < HistDepth; i++) begin
          hist_r[i] <= hist_nxt[i];
        end
      end
      phase_r <= phase_nxt;
      btv_r   <= btv_nxt;
      two_r   <= two_nxt;
      cmd_r   <= cmd_nxt;
      page_r  <= page_nxt;
    end
  end

endmodule

// ----- src/ocmp_out_reg.sv -----
module ocmp_out_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         res_valid,
  input  ocmp_pkg::res_t               res,
  output logic                         room,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ocmp_pkg::DataW-1:0]   out_tdata,
  output logic                         out_tuser
);
  import ocmp_pkg::*;

  logic valid_r;
  res_t data_r;

  // Room for a new item when no result is held or the held result leaves this cycle.
  assign room       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tuser  = data_r.event_res;
  assign out_tdata  = {7'd0, data_r.page, data_r.range_error_b, data_r.range_error_a,
                       data_r.switch_on, data_r.value_b, data_r.value_a,
                       data_r.control_number, data_r.control_kind};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room && res_valid) begin
      data_r <= res;
    end
  end

endmodule

// ----- src/osc_control_message_parser_core.sv -----
// OSC control message parser core.
// Input channel (in_*): one received serial byte per item in in_tdata.
// Output channel (out_*): one item per completed control update or per
// message restart error. out_tuser is the event flag (0 update, 1 restart
// error); out_tdata carries kind, number, both raw float words, the switch
// bit, the two range flags and the page number.
// A result appears on out_tvalid in the cycle after the byte that
// completes it is accepted. Throughput: one byte per cycle while in_tready
// is high; the parse state and byte history update in the accepting cycle
// and feed a single output register.
// Stall: while out_tvalid is high and out_tready low, in_tready is low and
// the held result stays; in_tready returns in the cycle the result is taken.
// Reset (rst_n low, synchronous): history, parse phase, countdown, command
// and page are cleared and the output register is emptied.
module osc_control_message_parser_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] rx_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [2:0] control_kind, [5:3] control_number, [37:6] value_a,
  // [69:38] value_b, [70] switch_on, [71] range_error_a,
  // [72] range_error_b, [80:73] page, [87:81] zero
  output logic [ocmp_pkg::DataW-1:0]  out_tdata,
  output logic                        out_tuser   // [0] event_res
);
  import ocmp_pkg::*;

  logic take;
  logic room;
  logic res_valid;
  res_t res;

  assign in_tready = room;
  assign take      = in_tvalid && room;

  ocmp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  ocmp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- tb/sv/tb_osc_control_message_parser_core.sv -----
`timescale 1ns / 100ps

module tb_osc_control_message_parser_core;
  import ocmp_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 300;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = 8'h00;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [DataW-1:0]    out_tdata;
  logic                out_tuser;

  osc_control_message_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  logic [7:0]  rx_backlog[$];
  res_t        pending_results[$];
  int unsigned planned = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_kick = 1'b0;
  int unsigned hold_cnt = 0;

  // Parser state as the block should hold it
  logic [7:0] hist [8] = '{default: 8'h00};
  phase_t     phase = PH_IDLE;
  logic [3:0] countdown = 4'd0;
  logic       pair_mode = 1'b0;
  logic [5:0] cmd = CmdNone;
  logic [7:0] page_reg = 8'h00;

  // Below 0.0 or above 1.0; NaN is never out of range
  function automatic logic beyond_unit(input logic [31:0] w);
    logic [7:0]  ex;
    logic [22:0] man;
    ex = w[30:23];
    man = w[22:0];
    if (ex == 8'hFF && man != 23'd0) return 1'b0;
    if (w[31]) return ex != 8'd0 || man != 23'd0;
    return ex > 8'd127 || (ex == 8'd127 && man != 23'd0);
  endfunction

  task automatic take_number(input logic [5:0] base);
    if (hist[0] >= ChOne && hist[0] <= ChFour) cmd = base + 6'(hist[0] - ChZero);
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    res_t r;
    for (int i = 7; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = b;
    r = '0;
    if (hist[0] == ChSlash && hist[2] == ChSlash) begin
      if (phase == PH_IDLE) begin
        page_reg = hist[1] - ChZero;
      end else begin
        r.event_res = EvRestart;
        r.page = page_reg;
        pending_results.push_back(r);
      end
      phase = PH_NAME;
    end else if (phase == PH_NAME) begin
      if (hist[3] == ChD && hist[2] == ChE && hist[1] == ChR) begin
        phase = PH_COUNT;
        countdown = CntFader;
        pair_mode = 1'b0;
        take_number(CmdFaderBase);
      end else if (hist[2] == ChX && hist[1] == ChY) begin
        phase = PH_COUNT;
        countdown = CntXy;
        pair_mode = 1'b1;
        cmd = (hist[0] == ChTwo) ? CmdXyBase + 6'd2 : CmdXyBase + 6'd1;
      end else if (hist[4] == ChP && hist[3] == ChU && hist[2] == ChS && hist[1] == ChH) begin
        phase = PH_COUNT;
        countdown = CntPush;
        pair_mode = 1'b0;
        take_number(CmdPushBase);
      end else if (hist[3] == ChG && hist[2] == ChL && hist[1] == ChE) begin
        phase = PH_COUNT;
        countdown = CntToggle;
        pair_mode = 1'b0;
        take_number(CmdTogBase);
      end
    end else if (phase == PH_COUNT) begin
      if (countdown > 4'd1) begin
        countdown = countdown - 4'd1;
      end else begin
        countdown = 4'd0;
        phase = PH_IDLE;
        r.event_res = EvUpdate;
        if (cmd > CmdFaderBase && cmd <= CmdFaderBase + 6'd4) begin
          r.control_kind = KindFader;
          r.control_number = 3'(cmd - CmdFaderBase);
        end else if (cmd > CmdXyBase && cmd <= CmdXyBase + 6'd2) begin
          r.control_kind = KindXy;
          r.control_number = 3'(cmd - CmdXyBase);
        end else if (cmd > CmdPushBase && cmd <= CmdPushBase + 6'd4) begin
          r.control_kind = KindPush;
          r.control_number = 3'(cmd - CmdPushBase);
        end else if (cmd > CmdTogBase && cmd <= CmdTogBase + 6'd4) begin
          r.control_kind = KindToggle;
          r.control_number = 3'(cmd - CmdTogBase);
        end
        r.value_a = {hist[3], hist[2], hist[1], hist[0]};
        r.value_b = pair_mode ? {hist[7], hist[6], hist[5], hist[4]} : 32'd0;
        r.switch_on = r.value_a[30:0] != 31'd0;
        r.range_error_a = beyond_unit(r.value_a);
        r.range_error_b = pair_mode ? beyond_unit(r.value_b) : 1'b0;
        r.page = page_reg;
        pending_results.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) absorb_byte(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata <= rx_backlog.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_kick) begin
      hold_cnt <= HoldCycles;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: tuser %0b tdata %0h", out_tuser, out_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("event_res", want.event_res, out_tuser);
          check_field("control_kind", want.control_kind, out_tdata[2:0]);
          check_field("control_number", want.control_number, out_tdata[5:3]);
          check_field("value_a", want.value_a, out_tdata[37:6]);
          check_field("value_b", want.value_b, out_tdata[69:38]);
          check_field("switch_on", want.switch_on, out_tdata[70]);
          check_field("range_error_a", want.range_error_a, out_tdata[71]);
          check_field("range_error_b", want.range_error_b, out_tdata[72]);
          check_field("page", want.page, out_tdata[80:73]);
        end
      end
      out_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_osc_control_message_parser_core NOT OK");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_backlog.push_back(b);
    planned++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [31:0] pick_float();
    case ($urandom_range(11))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h3F80_0000;
      3:       return 32'h3F80_0001;
      4:       return 32'h7F80_0000;
      5:       return 32'hFF80_0000;
      6:       return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
      7:       return {1'b1, 31'($urandom())};
      8:       return {1'b0, 8'd126, 23'($urandom())};
      9:       return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  // Build one message; drop its tail to leave it open, or skip the header so it is ignored
  task automatic queue_message(input bit with_header, input int unsigned drop);
    logic [7:0]  msg[$];
    logic [31:0] va;
    logic [31:0] vb;
    string       name;
    int unsigned fill;
    int unsigned kind;
    va = pick_float();
    vb = pick_float();
    kind = $urandom_range(3);
    if (with_header) begin
      msg.push_back(ChSlash);
      msg.push_back(($urandom_range(9) != 0) ? ChZero + 8'($urandom_range(9))
                                              : 8'($urandom_range(255)));
      msg.push_back(ChSlash);
    end
    case (kind)
      0:       begin name = "fader";  fill = CntFader - 4;  end
      1:       begin name = "xy";     fill = CntXy - 8;     end
      2:       begin name = "push";   fill = CntPush - 4;   end
      default: begin name = "toggle"; fill = CntToggle - 4; end
    endcase
    for (int i = 0; i < name.len(); i++) msg.push_back(name[i]);
    if ($urandom_range(7) == 0) msg.push_back(8'($urandom_range(255)));
    else if (kind == 1) msg.push_back(ChZero + 8'($urandom_range(1, 2)));
    else msg.push_back(ChZero + 8'($urandom_range(1, 4)));
    for (int i = 0; i < fill; i++) begin
      msg.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'h00);
    end
    if (kind == 1) begin
      for (int i = 3; i >= 0; i--) msg.push_back(vb[8*i +: 8]);
    end
    for (int i = 3; i >= 0; i--) msg.push_back(va[8*i +: 8]);
    if (drop >= msg.size()) drop = msg.size() - 1;
    for (int i = 0; i < msg.size() - drop; i++) push_byte(msg[i]);
  endtask

  task automatic queue_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned sel;
    stop_at = planned + count;
    while (planned < stop_at) begin
      sel = $urandom_range(19);
      if (sel < 14) begin
        queue_message(1'b1, 0);
      end else if (sel < 16) begin
        queue_message(1'b1, $urandom_range(1, 12));
      end else if (sel < 17) begin
        queue_message(1'b0, 0);
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic drain();
    while (rx_backlog.size() != 0 || in_tvalid || pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 82;
    // all-ones and all-zero bytes, a start, a restart, then a fader with a bad digit
    // while no command is set yet, so the update carries no kind
    push_byte(8'hFF);
    push_byte(8'h00);
    push_str("/5//7/fader9");
    repeat (3) push_byte(8'h00);
    push_str(",f");
    repeat (2) push_byte(8'h00);
    push_byte(8'h3F);
    push_byte(8'h80);
    push_byte(8'h00);
    push_byte(8'h00);
    queue_traffic(460);
    drain();

    send_idle_pct = 82;
    recv_idle_pct = 24;
    queue_traffic(480);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_traffic(480);
    // hold the output off while bytes keep coming
    hold_kick = 1'b1;
    @(negedge clk);
    hold_kick = 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("tb_osc_control_message_parser_core OK");
    end else begin
      $display("tb_osc_control_message_parser_core NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ocmp_pkg.sv
src/ocmp_parser.sv
src/ocmp_out_reg.sv
src/osc_control_message_parser_core.sv
tb/sv/tb_osc_control_message_parser_core.sv
